// ===== rtl/core/tcw_pkg.sv =====
// shared types and constants for the text console writer
package tcw_pkg;

   localparam int OP_W        = 2;
   localparam int CHAR_W      = 8;
   localparam int INDEX_W     = 11;
   localparam int DATA_W      = 16;
   localparam int POS_W       = 11;
   localparam int COLOR_W     = 4;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam logic [COLOR_W-1:0] RESET_FG = 4'h7;
   localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;
   localparam logic [DATA_W-1:0]  RESET_BLANK = {RESET_BG, RESET_FG, CH_SPACE};

   localparam logic [CSR_INDEX_W-1:0] CSR_FG = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG = 1'b1;

   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_NEWLINE,
      CMD_RETURN,
      CMD_BACKSPACE,
      CMD_READ,
      CMD_CLEAR,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [CHAR_W-1:0]   char_code;
      logic [INDEX_W-1:0]  cell_index;
   } cmd_type;

endpackage

// ===== rtl/core/text_console_writer.sv =====
// top level of the text console writer
// Text console of COLUMNS x ROWS 16-bit cells (character low byte, attribute
// bg<<4|fg high byte) with a cursor. Request words go through a two-entry queue
// to the back end, which owns a simple dual-port cell store (one write and one
// read per cycle). A put, return, backspace, newline without scroll or out-of-range
// read is handled in the idle state; a read also passes through the read state. A
// newline or wrap on the last row scrolls the store (copy, then blank bottom row).
// A clear sweeps the whole store. After reset the block blanks the store before it
// starts on requests (the queue still takes two words meanwhile); configuration
// writes are taken at any time.
// Every request returns one response word with the cell value for reads (zero
// otherwise) and the linear cursor position.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // operation [1:0], char_code [9:2], cell_index [20:10], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_data [15:0], cursor_pos [26:16], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_wdata
);

   logic [COLOR_W-1:0] fg_ff, fg_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;

   logic    q_full;
   logic    q_push;
   cmd_type push_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type head_cmd;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FG:  fg_in = csr_wdata;
            CSR_BG:  bg_in = csr_wdata;
            default: fg_in = fg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= RESET_FG;
         bg_ff <= RESET_BG;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (head_cmd)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fg_color   (fg_ff),
      .bg_color   (bg_ff),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/tcw_front.sv =====
// front end: takes request words and classifies them into commands
module tcw_front
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   q_full,
   output logic                   q_push,
   output cmd_type                q_cmd
);

   localparam int CELLS = COLUMNS * ROWS;

   logic [OP_W-1:0]    op;
   logic [CHAR_W-1:0]  ch;
   logic [INDEX_W-1:0] idx;

   assign op  = req_tdata[OP_W-1:0];
   assign ch  = req_tdata[OP_W+CHAR_W-1:OP_W];
   assign idx = req_tdata[OP_W+CHAR_W+INDEX_W-1:OP_W+CHAR_W];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_cmd.char_code  = ch;
      q_cmd.cell_index = idx;
      unique case (op)
         OP_PUT: begin
            unique case (ch)
               CH_NEWLINE:   q_cmd.kind = CMD_NEWLINE;
               CH_RETURN:    q_cmd.kind = CMD_RETURN;
               CH_BACKSPACE: q_cmd.kind = CMD_BACKSPACE;
               default:      q_cmd.kind = CMD_PUT;
            endcase
         end
         OP_READ: begin
            if (32'(idx) < 32'(CELLS)) begin
               q_cmd.kind = CMD_READ;
            end else begin
               q_cmd.kind = CMD_NOP;
            end
         end
         OP_CLEAR: q_cmd.kind = CMD_CLEAR;
         default:  q_cmd.kind = CMD_NOP;
      endcase
   end

endmodule

// ===== rtl/core/tcw_queue.sv =====
// two-entry command queue between front and back end
module tcw_queue
   import tcw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type head
);

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   assign full  = (count_ff == (PW+1)'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = (PW+1)'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = (PW+1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/tcw_back.sv =====
// back end: cell store, cursor, scroll and clear sweeps, response register
module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [COLOR_W-1:0]     fg_color,
   input  logic [COLOR_W-1:0]     bg_color,
   input  logic                   q_valid,
   input  cmd_type                q_cmd,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int SHIFT = CELLS - COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int PW    = $clog2(CELLS + 1);

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_COPY  = 6'b001000,
      ST_BLANK = 6'b010000,
      ST_CLEAR = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic               pend_ff, pend_in;
   logic [CHAR_W-1:0]  pend_char_ff, pend_char_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic [POS_W-1:0]   rsp_pos_ff;

   logic [DATA_W-1:0]  mem [CELLS];
   logic [DATA_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [DATA_W-1:0]  mem_wdata;
   logic [AW-1:0]      mem_raddr;

   logic               slot_free;
   logic               rsp_load;
   logic [DATA_W-1:0]  rsp_rdata;
   logic [CW-1:0]      wcol;
   logic [RW-1:0]      wrow;
   logic [PW-1:0]      pos_full;
   logic [2*COLOR_W-1:0] attr;
   logic [DATA_W-1:0]  blank;
   logic               last_row;
   logic               row_full;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                               input logic [RW-1:0] r);
      return AW'(c) + AW'(AW'(r) * AW'(COLUMNS));
   endfunction

   assign attr      = {bg_color, fg_color};
   assign blank     = {attr, CH_SPACE};
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign last_row  = (row_ff == RW'(ROWS - 1));
   assign row_full  = (col_ff >= CW'(COLUMNS));
   assign pos_full  = PW'(col_in) + PW'(PW'(row_in) * PW'(COLUMNS));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pend_in      = pend_ff;
      pend_char_in = pend_char_ff;
      mem_we       = 1'b0;
      mem_waddr    = cell_addr(col_ff, row_ff);
      mem_wdata    = blank;
      mem_raddr    = AW'(q_cmd.cell_index);
      q_pop        = 1'b0;
      rsp_load     = 1'b0;
      rsp_rdata    = '0;
      wcol         = col_ff;
      wrow         = row_ff;

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = RESET_BLANK;
            if (cnt_ff == AW'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = AW'(cnt_ff + 1'b1);
            end
         end
         ST_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  CMD_PUT: begin
                     if (row_full && last_row) begin
                        col_in       = CW'(1);
                        cnt_in       = '0;
                        pend_in      = 1'b1;
                        pend_char_in = q_cmd.char_code;
                        state_in     = ST_COPY;
                     end else begin
                        if (row_full) begin
                           wcol   = '0;
                           wrow   = RW'(row_ff + 1'b1);
                           row_in = wrow;
                        end
                        mem_we    = 1'b1;
                        mem_waddr = cell_addr(wcol, wrow);
                        mem_wdata = {attr, q_cmd.char_code};
                        col_in    = CW'(wcol + 1'b1);
                        rsp_load  = 1'b1;
                     end
                  end
                  CMD_NEWLINE: begin
                     col_in = '0;
                     if (last_row) begin
                        cnt_in   = '0;
                        pend_in  = 1'b0;
                        state_in = ST_COPY;
                     end else begin
                        row_in   = RW'(row_ff + 1'b1);
                        rsp_load = 1'b1;
                     end
                  end
                  CMD_RETURN: begin
                     col_in   = '0;
                     rsp_load = 1'b1;
                  end
                  CMD_BACKSPACE: begin
                     wcol      = (col_ff == '0) ? '0 : CW'(col_ff - 1'b1);
                     col_in    = wcol;
                     mem_we    = 1'b1;
                     mem_waddr = cell_addr(wcol, row_ff);
                     rsp_load  = 1'b1;
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  CMD_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load  = 1'b1;
            rsp_rdata = rd_data_ff;
            state_in  = ST_IDLE;
         end
         ST_COPY: begin
            mem_raddr = AW'(cnt_ff + AW'(COLUMNS));
            mem_we    = (cnt_ff != '0);
            mem_waddr = AW'(cnt_ff - 1'b1);
            mem_wdata = rd_data_ff;
            if (cnt_ff == AW'(SHIFT)) begin
               state_in = ST_BLANK;
            end else begin
               cnt_in = AW'(cnt_ff + 1'b1);
            end
         end
         ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            if (pend_ff && cnt_ff == AW'(SHIFT)) begin
               mem_wdata = {attr, pend_char_ff};
            end
            if (cnt_ff == AW'(CELLS - 1)) begin
               pend_in  = 1'b0;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cnt_in = AW'(cnt_ff + 1'b1);
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            if (cnt_ff == AW'(CELLS - 1)) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cnt_in = AW'(cnt_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_char_ff <= pend_char_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_rdata;
         rsp_pos_ff  <= POS_W'(pos_full);
      end
   end

   // cell store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - DATA_W - POS_W)'(0), rsp_pos_ff, rsp_data_ff};

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("command taken while back end busy");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> slot_free)
      else $error("response overwritten before taken");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= CW'(COLUMNS) && row_ff <= RW'(ROWS - 1))
      else $error("cursor out of range");

   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> cnt_ff <= AW'(SHIFT))
      else $error("scroll counter out of range");

   a_pend_scroll: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_COPY || state_ff == ST_BLANK))
      else $error("pending character outside a scroll");

endmodule
